### sv/bsc_pkg.sv
`timescale 1ns / 1ps

package bsc_pkg;

   localparam int CoordWidth = 32;
   localparam int SumWidth   = CoordWidth + 3;

   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec_type;

   // One item moving between cells: a point plus its end-of-line mark
   typedef struct packed {
      vec_type pos;
      logic    last;
   } point_type;

   // Smooth: floor((a + 6b + c) / 8); mid: floor((b + c) / 2) done as (4b + 4c) / 8
   function automatic coord_type blend_axis(input coord_type a, input coord_type b,
                                            input coord_type c, input logic smooth);
      logic signed [SumWidth-1:0] ea;
      logic signed [SumWidth-1:0] eb;
      logic signed [SumWidth-1:0] ec;
      logic signed [SumWidth-1:0] sum;
      ea = {{3{a[CoordWidth-1]}}, a};
      eb = {{3{b[CoordWidth-1]}}, b};
      ec = {{3{c[CoordWidth-1]}}, c};
      if (smooth) begin
         sum = ea + (eb <<< 2) + (eb <<< 1) + ec;
      end else begin
         sum = (eb <<< 2) + (ec <<< 2);
      end
      return sum[SumWidth-1:3];
   endfunction

   function automatic vec_type blend(input vec_type a, input vec_type b, input vec_type c,
                                     input logic smooth);
      vec_type r;
      r.x = blend_axis(a.x, b.x, c.x, smooth);
      r.y = blend_axis(a.y, b.y, c.y, smooth);
      r.z = blend_axis(a.z, b.z, c.z, smooth);
      return r;
   endfunction

endpackage

### sv/bspline_curve_subdivision.sv
`timescale 1ns / 1ps

// Cubic B-spline subdivision of a streamed 3D polyline (Q16.16 coordinates).
// Input items (req_*) carry one point each; req_end_of_line marks a line's
// last point. Result items (rsp_*) carry refined points; rsp_final_point
// marks the last refined point of a line. Both channels move an item on a
// clock edge where valid is high and stall is low.
// csr_passes (0..4, larger acts as MAX_PASSES) sets how many cells refine;
// the rest pass items through. Write it only while the block is idle.
// Each cell turns one item into 1 to 4 items at one per cycle while its
// output is not stalled. With k passes an input item yields up to 2^k
// results, or up to 3 * 2^k - 2 for a line's last point (46 at four
// passes). The block sustains one result per cycle while rsp_stall is
// low, set by the last cell's output register. Each cell holds an
// accepted item in its input buffer and registers each result in its
// output register.
// Reset clears all line history and sets passes to 1. When rsp_stall is
// high, results hold and back pressure ripples up the chain to req_stall.
module bspline_curve_subdivision #(
   parameter int MAX_PASSES = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [31:0]      req_px,
   input  logic signed [31:0]      req_py,
   input  logic signed [31:0]      req_pz,
   input  logic                    req_end_of_line,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [31:0]      rsp_qx,
   output logic signed [31:0]      rsp_qy,
   output logic signed [31:0]      rsp_qz,
   output logic                    rsp_final_point,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_passes
);

   logic [2:0]          passes_ff;
   logic                link_valid [MAX_PASSES+1];
   logic                link_stall [MAX_PASSES+1];
   bsc_pkg::point_type  link_point [MAX_PASSES+1];

   // Configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         passes_ff <= 3'd1;
      end else if (csr_valid && csr_ready) begin
         passes_ff <= csr_passes;
      end
   end

   // Chain head
   assign link_valid[0]          = req_valid;
   assign req_stall              = link_stall[0];
   assign link_point[0].pos.x    = req_px;
   assign link_point[0].pos.y    = req_py;
   assign link_point[0].pos.z    = req_pz;
   assign link_point[0].last     = req_end_of_line;

   for (genvar i = 0; i < MAX_PASSES; i++) begin : g_cell
      bsc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .active    (passes_ff > 3'(i)),
         .in_valid  (link_valid[i]),
         .in_stall  (link_stall[i]),
         .in_point  (link_point[i]),
         .out_valid (link_valid[i+1]),
         .out_stall (link_stall[i+1]),
         .out_point (link_point[i+1])
      );
   end

   // Chain tail
   assign rsp_valid                 = link_valid[MAX_PASSES];
   assign link_stall[MAX_PASSES]    = rsp_stall;
   assign rsp_qx                    = link_point[MAX_PASSES].pos.x;
   assign rsp_qy                    = link_point[MAX_PASSES].pos.y;
   assign rsp_qz                    = link_point[MAX_PASSES].pos.z;
   assign rsp_final_point           = link_point[MAX_PASSES].last;

endmodule

### sv/bsc_cell.sv
`timescale 1ns / 1ps

// One subdivision pass. Holds one incoming item and emits its 1 to 4 refined
// items, one per cycle while out_stall is low, into a registered output stage.
module bsc_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 active,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  bsc_pkg::point_type   in_point,
   output logic                 out_valid,
   input  logic                 out_stall,
   output bsc_pkg::point_type   out_point
);

   logic                buf_valid_ff;
   bsc_pkg::point_type  buf_ff;
   logic [1:0]          phase_ff;
   logic [1:0]          phase_in;
   logic                out_valid_ff;
   bsc_pkg::point_type  out_ff;
   bsc_pkg::vec_type    older_ff;
   bsc_pkg::vec_type    newer_ff;
   logic [1:0]          seen_ff;

   logic                out_free;
   logic                fire;
   logic                done;
   logic [1:0]          last_phase;
   logic                first_of_line;
   bsc_pkg::vec_type    op_a;
   bsc_pkg::vec_type    op_b;
   bsc_pkg::vec_type    op_c;
   logic                smooth;
   bsc_pkg::point_type  result;

   assign out_free      = !out_valid_ff || !out_stall;
   assign fire          = buf_valid_ff && out_free;
   assign first_of_line = (seen_ff == 2'd0);

   // Items emitted per input minus one
   always_comb begin
      if (!active) begin
         last_phase = 2'd0;
      end else if (first_of_line) begin
         last_phase = buf_ff.last ? 2'd2 : 2'd0;
      end else begin
         last_phase = buf_ff.last ? 2'd3 : 2'd1;
      end
   end

   assign done     = fire && (phase_ff == last_phase);
   assign in_stall = buf_valid_ff && !done;

   // Operand selection per phase; a lone first point blends with itself
   always_comb begin
      op_a   = buf_ff.pos;
      op_b   = buf_ff.pos;
      op_c   = buf_ff.pos;
      smooth = 1'b1;
      if (active && !first_of_line) begin
         unique case (phase_ff)
            2'd0: begin
               op_a = (seen_ff == 2'd1) ? newer_ff : older_ff;
               op_b = newer_ff;
            end
            2'd1: begin
               op_b   = newer_ff;
               smooth = 1'b0;
            end
            2'd2: begin
               op_a = newer_ff;
            end
            2'd3: begin
               smooth = 1'b0;
            end
            default: begin
               smooth = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      result.pos  = bsc_pkg::blend(op_a, op_b, op_c, smooth);
      result.last = buf_ff.last && (phase_ff == last_phase);
   end

   assign phase_in = done ? 2'd0 : (fire ? phase_ff + 2'd1 : phase_ff);

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         phase_ff     <= 2'd0;
         out_valid_ff <= 1'b0;
         seen_ff      <= 2'd0;
         older_ff     <= '0;
         newer_ff     <= '0;
      end else begin
         phase_ff <= phase_in;
         if (in_valid && !in_stall) begin
            buf_valid_ff <= 1'b1;
         end else if (done) begin
            buf_valid_ff <= 1'b0;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (!out_stall) begin
            out_valid_ff <= 1'b0;
         end
         // Line history advances once the item is fully emitted
         if (done && active) begin
            older_ff <= newer_ff;
            newer_ff <= buf_ff.pos;
            if (buf_ff.last) begin
               seen_ff <= 2'd0;
            end else begin
               seen_ff <= first_of_line ? 2'd1 : 2'd2;
            end
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         buf_ff <= in_point;
      end
      if (fire) begin
         out_ff <= result;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_point = out_ff;

endmodule
